// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types, codes and GF(2^8) helper functions for the RS(10,8)
// single-symbol correcting decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int unsigned NSYM       = 10;
   localparam int unsigned SYM_W      = 8;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef logic [SYM_W-1:0] sym_type;
   typedef sym_type [NSYM-1:0] sym_array_type;

   // Result status as shown on the response channel.
   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_CORR = 2'd1,
      ST_DUE  = 2'd2
   } status_type;

   // Classification made by the front end.
   typedef enum logic [1:0] {
      CLS_CLEAN  = 2'd0,
      CLS_LOCATE = 2'd1,
      CLS_DUE    = 2'd2
   } cls_type;

   // One classified word as it travels through the queue.
   typedef struct packed {
      sym_array_type sym;
      sym_type       s0;
      sym_type       log_s0;
      sym_type       log_s1;
      cls_type       cls;
   } entry_type;

   // Bit 8 marks a valid logarithm, bits 7:0 hold it.
   typedef logic [SYM_W:0] log_entry_type;
   typedef log_entry_type [255:0] log_table_type;

   function automatic sym_type gf_xtime(sym_type v, sym_type poly);
      return {v[SYM_W-2:0], 1'b0} ^ (v[SYM_W-1] ? poly : '0);
   endfunction

   // Multiply by alpha^n as n shifts through the field polynomial.
   function automatic sym_type gf_mul_alpha(sym_type v, int unsigned n, sym_type poly);
      sym_type r;
      r = v;
      for (int unsigned k = 0; k < n; k++) begin
         r = gf_xtime(r, poly);
      end
      return r;
   endfunction

   // Log table; the first exponent reaching a value wins, values never
   // reached stay marked invalid.
   function automatic log_table_type gf_build_log(sym_type poly);
      log_table_type t;
      sym_type       p;
      t = '0;
      p = 8'h01;
      for (int k = 0; k < 255; k++) begin
         if (!t[p][SYM_W]) begin
            t[p] = {1'b1, 8'(k)};
         end
         p = gf_xtime(p, poly);
      end
      return t;
   endfunction

endpackage

// ===== rtl/core/rsd_front.sv =====
// ----------------------------------------------------------------------------
// rsd_front
// Forms both syndromes of an incoming word, looks up their logarithms and
// classifies the word for the back end.
// ----------------------------------------------------------------------------
module rsd_front import rsd_pkg::*; #(
   parameter logic [7:0] POLY = 8'h1D
) (
   input  sym_array_type sym,
   output entry_type     entry
);

   localparam log_table_type LOG_TABLE = gf_build_log(POLY);

   sym_type       s0;
   sym_type       s1;
   log_entry_type lg0;
   log_entry_type lg1;

   always_comb begin
      s0 = '0;
      s1 = '0;
      for (int unsigned i = 0; i < NSYM; i++) begin
         s0 = s0 ^ sym[i];
         s1 = s1 ^ gf_mul_alpha(sym[i], i, POLY);
      end
   end

   assign lg0 = LOG_TABLE[s0];
   assign lg1 = LOG_TABLE[s1];

   always_comb begin
      entry.sym    = sym;
      entry.s0     = s0;
      entry.log_s0 = lg0[SYM_W-1:0];
      entry.log_s1 = lg1[SYM_W-1:0];
      if (s0 == '0 && s1 == '0) begin
         entry.cls = CLS_CLEAN;
      end else if (s0 != '0 && s1 != '0 && lg0[SYM_W] && lg1[SYM_W]) begin
         entry.cls = CLS_LOCATE;
      end else begin
         entry.cls = CLS_DUE;
      end
   end

endmodule

// ===== rtl/core/rsd_queue.sv =====
// ----------------------------------------------------------------------------
// rsd_queue
// Short first-in first-out queue of classified words between the front
// end and the back end.
// ----------------------------------------------------------------------------
module rsd_queue import rsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_entry
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   entry_type        store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/rsd_back.sv =====
// ----------------------------------------------------------------------------
// rsd_back
// Turns the syndrome logarithms into an error position, repairs the symbol
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module rsd_back import rsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  entry_type     in_entry,
   output logic          in_take,
   output logic          out_valid,
   input  logic          out_stall,
   output sym_array_type out_fix,
   output status_type    out_status,
   output logic [POS_W-1:0] out_pos
);

   logic             out_valid_ff, out_valid_in;
   sym_array_type    fix_ff, fix_in;
   status_type       status_ff, status_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   sym_type diff;
   sym_type pos_full;

   assign in_take = in_valid && (!out_valid_ff || !out_stall);

   // Position is (log S1 - log S0) mod 255 with both logs below 255.
   always_comb begin
      diff     = in_entry.log_s1 - in_entry.log_s0;
      pos_full = (in_entry.log_s1 < in_entry.log_s0) ? diff - 1'b1 : diff;
   end

   always_comb begin
      fix_in    = in_entry.sym;
      status_in = ST_DUE;
      pos_in    = '0;
      unique case (in_entry.cls)
         CLS_CLEAN: begin
            status_in = ST_NONE;
         end
         CLS_LOCATE: begin
            if (pos_full < SYM_W'(NSYM)) begin
               status_in = ST_CORR;
               pos_in    = pos_full[POS_W-1:0];
               for (int unsigned i = 0; i < NSYM; i++) begin
                  if (pos_full == SYM_W'(i)) begin
                     fix_in[i] = in_entry.sym[i] ^ in_entry.s0;
                  end
               end
            end
         end
         default: begin
            status_in = ST_DUE;
         end
      endcase
   end

   assign out_valid_in = (!out_valid_ff || !out_stall) ? in_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         fix_ff    <= fix_in;
         status_ff <= status_in;
         pos_ff    <= pos_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_fix    = fix_ff;
   assign out_status = status_ff;
   assign out_pos    = pos_ff;

endmodule

// ===== rtl/core/rs_single_symbol_correct_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rs_single_symbol_correct_decoder_top
// Reed-Solomon (10,8) decoder over GF(2^8) that corrects one bad symbol.
// ----------------------------------------------------------------------------
// A request word carries ten 8-bit symbols on req_sym_0..req_sym_9 and is
// taken at a rising edge where req_valid is high and req_stall is low.
// Each request produces exactly one response word on rsp_fix_0..rsp_fix_9,
// rsp_status and rsp_err_pos, handed over at an edge where rsp_valid is
// high and rsp_stall is low.
// The front end computes both syndromes and their logarithms from the table
// in the same cycle the word is taken and writes the classified word into a
// two-word queue. The back end takes the word at the head of the queue,
// derives the error position, repairs the symbol and loads the output
// register, so each response passes through the queue and then the output register.
// One word per cycle is sustained while the receiver does not stall; the rate is
// set by the queue and the single output register, each moving one word per cycle.
// When the receiver stalls, the response holds steady, the queue fills and
// req_stall rises once both queue entries are occupied.
// Reset clears the queue and the output valid; no word is in flight after.
// ----------------------------------------------------------------------------
module rs_single_symbol_correct_decoder_top import rsd_pkg::*; #(
   parameter int FIELD_POLY = 29
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_sym_0,
   input  logic [7:0] req_sym_1,
   input  logic [7:0] req_sym_2,
   input  logic [7:0] req_sym_3,
   input  logic [7:0] req_sym_4,
   input  logic [7:0] req_sym_5,
   input  logic [7:0] req_sym_6,
   input  logic [7:0] req_sym_7,
   input  logic [7:0] req_sym_8,
   input  logic [7:0] req_sym_9,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_fix_0,
   output logic [7:0] rsp_fix_1,
   output logic [7:0] rsp_fix_2,
   output logic [7:0] rsp_fix_3,
   output logic [7:0] rsp_fix_4,
   output logic [7:0] rsp_fix_5,
   output logic [7:0] rsp_fix_6,
   output logic [7:0] rsp_fix_7,
   output logic [7:0] rsp_fix_8,
   output logic [7:0] rsp_fix_9,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_err_pos
);

   // Only the low byte of the polynomial matters; x^8 is implied.
   localparam logic [7:0] POLY_BYTE = 8'(FIELD_POLY);

   sym_array_type    req_sym;
   entry_type        front_entry;
   entry_type        queue_entry;
   logic             queue_full;
   logic             queue_not_empty;
   logic             back_take;
   logic             push;
   sym_array_type    fix;
   status_type       status;
   logic [POS_W-1:0] err_pos;

   assign req_sym = {req_sym_9, req_sym_8, req_sym_7, req_sym_6, req_sym_5,
                     req_sym_4, req_sym_3, req_sym_2, req_sym_1, req_sym_0};

   // The stall comes straight from the queue state, never from req_valid.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   rsd_front #(
      .POLY (POLY_BYTE)
   ) u_front (
      .sym   (req_sym),
      .entry (front_entry)
   );

   rsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (back_take),
      .not_empty  (queue_not_empty),
      .pop_entry  (queue_entry)
   );

   rsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_not_empty),
      .in_entry   (queue_entry),
      .in_take    (back_take),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_fix    (fix),
      .out_status (status),
      .out_pos    (err_pos)
   );

   assign rsp_fix_0   = fix[0];
   assign rsp_fix_1   = fix[1];
   assign rsp_fix_2   = fix[2];
   assign rsp_fix_3   = fix[3];
   assign rsp_fix_4   = fix[4];
   assign rsp_fix_5   = fix[5];
   assign rsp_fix_6   = fix[6];
   assign rsp_fix_7   = fix[7];
   assign rsp_fix_8   = fix[8];
   assign rsp_fix_9   = fix[9];
   assign rsp_status  = status;
   assign rsp_err_pos = err_pos;

endmodule

// ===== rtl/core/rsd_checker.sv =====
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks on the decoder response channel, bound to the top level.
// ----------------------------------------------------------------------------
module rsd_checker import rsd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_fix_0,
   input logic [7:0] rsp_fix_9,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_err_pos
);

   // A stalled response word stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_err_pos) && $stable(rsp_fix_0) && $stable(rsp_fix_9))
      else $error("stalled response word changed");

   // Reset leaves no response in flight.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only a corrected word names a position.
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_CORR |-> rsp_err_pos == '0)
      else $error("error position set without a correction");

   // A corrected position lies inside the codeword.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CORR |-> rsp_err_pos < 4'(NSYM))
      else $error("corrected position outside the codeword");

endmodule

bind rs_single_symbol_correct_decoder_top rsd_checker u_rsd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_fix_0   (rsp_fix_0),
   .rsp_fix_9   (rsp_fix_9),
   .rsp_status  (rsp_status),
   .rsp_err_pos (rsp_err_pos)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RS(10,8) single-symbol correcting decoder.
// Words go in with random gaps and come out against random back-pressure.
// Each response is compared field by field against a typed-in or behavioral decode.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsd_pkg::*;

   localparam int          POLY       = 29;
   localparam logic [7:0]  POLY8      = 8'(POLY);
   localparam int          CYCLE_LIMIT = 400_000;
   localparam int          NDIR       = 18;
   localparam int          PHASE_WORDS = 511;
   localparam int          HOLD_CYCLES = 300;

   // Ten symbols, symbol 0 in the most significant byte, as on the wire.
   typedef logic [0:9][7:0] word_type;

   typedef struct packed {
      word_type    fix;
      status_type  st;
      logic [3:0]  pos;
   } result_type;

   // A directed row: a typed-in result is used only where known is set.
   typedef struct packed {
      word_type    sym;
      logic        known;
      status_type  st;
      logic [3:0]  pos;
      word_type    fix;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_sym_0 = '0;
   logic [7:0] req_sym_1 = '0;
   logic [7:0] req_sym_2 = '0;
   logic [7:0] req_sym_3 = '0;
   logic [7:0] req_sym_4 = '0;
   logic [7:0] req_sym_5 = '0;
   logic [7:0] req_sym_6 = '0;
   logic [7:0] req_sym_7 = '0;
   logic [7:0] req_sym_8 = '0;
   logic [7:0] req_sym_9 = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_fix_0, rsp_fix_1, rsp_fix_2, rsp_fix_3, rsp_fix_4;
   logic [7:0] rsp_fix_5, rsp_fix_6, rsp_fix_7, rsp_fix_8, rsp_fix_9;
   logic [1:0] rsp_status;
   logic [3:0] rsp_err_pos;

   // Expected decodes, oldest first, pushed when the request word is taken.
   result_type expected_decodes [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_armed = 1'b0;
   bit  hold_taken = 1'b0;
   int  cycle_count = 0;
   int  blocked_cycles = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  mismatches = 0;
   int  seen_clean = 0;
   int  seen_corrected = 0;
   int  seen_uncorrectable = 0;

   // Directed words: the all-zero word, a single bad symbol at every position
   // on the zero word (which must repair back to zero), each syndrome zero on
   // its own, and a few multi-symbol patterns left to the behavioral decoder.
   row_type directed_rows [NDIR] = '{
      '{80'h00_00_00_00_00_00_00_00_00_00, 1'b1, ST_NONE, 4'd0, 80'h0},
      '{80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b0, ST_NONE, 4'd0, 80'h0},
      '{80'hFF_00_00_00_00_00_00_00_00_00, 1'b1, ST_CORR, 4'd0, 80'h0},
      '{80'h00_01_00_00_00_00_00_00_00_00, 1'b1, ST_CORR, 4'd1, 80'h0},
      '{80'h00_00_55_00_00_00_00_00_00_00, 1'b1, ST_CORR, 4'd2, 80'h0},
      '{80'h00_00_00_AA_00_00_00_00_00_00, 1'b1, ST_CORR, 4'd3, 80'h0},
      '{80'h00_00_00_00_0F_00_00_00_00_00, 1'b1, ST_CORR, 4'd4, 80'h0},
      '{80'h00_00_00_00_00_F0_00_00_00_00, 1'b1, ST_CORR, 4'd5, 80'h0},
      '{80'h00_00_00_00_00_00_80_00_00_00, 1'b1, ST_CORR, 4'd6, 80'h0},
      '{80'h00_00_00_00_00_00_00_7F_00_00, 1'b1, ST_CORR, 4'd7, 80'h0},
      '{80'h00_00_00_00_00_00_00_00_01_00, 1'b1, ST_CORR, 4'd8, 80'h0},
      '{80'h00_00_00_00_00_00_00_00_00_80, 1'b1, ST_CORR, 4'd9, 80'h0},
      '{80'h3C_3C_00_00_00_00_00_00_00_00, 1'b1, ST_DUE,  4'd0,
        80'h3C_3C_00_00_00_00_00_00_00_00},
      '{80'h02_01_00_00_00_00_00_00_00_00, 1'b1, ST_DUE,  4'd0,
        80'h02_01_00_00_00_00_00_00_00_00},
      '{80'h01_03_00_00_00_00_00_00_00_00, 1'b0, ST_NONE, 4'd0, 80'h0},
      '{80'h01_23_45_67_89_AB_CD_EF_00_11, 1'b0, ST_NONE, 4'd0, 80'h0},
      '{80'h80_80_80_80_80_80_80_80_80_80, 1'b0, ST_NONE, 4'd0, 80'h0},
      '{80'h01_01_01_01_01_01_01_01_01_01, 1'b0, ST_NONE, 4'd0, 80'h0}
   };

   rs_single_symbol_correct_decoder_top #(.FIELD_POLY(POLY)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sym_0   (req_sym_0),
      .req_sym_1   (req_sym_1),
      .req_sym_2   (req_sym_2),
      .req_sym_3   (req_sym_3),
      .req_sym_4   (req_sym_4),
      .req_sym_5   (req_sym_5),
      .req_sym_6   (req_sym_6),
      .req_sym_7   (req_sym_7),
      .req_sym_8   (req_sym_8),
      .req_sym_9   (req_sym_9),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_fix_0   (rsp_fix_0),
      .rsp_fix_1   (rsp_fix_1),
      .rsp_fix_2   (rsp_fix_2),
      .rsp_fix_3   (rsp_fix_3),
      .rsp_fix_4   (rsp_fix_4),
      .rsp_fix_5   (rsp_fix_5),
      .rsp_fix_6   (rsp_fix_6),
      .rsp_fix_7   (rsp_fix_7),
      .rsp_fix_8   (rsp_fix_8),
      .rsp_fix_9   (rsp_fix_9),
      .rsp_status  (rsp_status),
      .rsp_err_pos (rsp_err_pos)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Behavioral decoder
   // ------------------------------------------------------------------------

   // One multiplication by alpha = 0x02, reducing through the field polynomial.
   function automatic logic [7:0] times_alpha(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? POLY8 : 8'h00);
   endfunction

   function automatic logic [7:0] scale_by_alpha(input logic [7:0] v, input int n);
      logic [7:0] acc;
      acc = v;
      for (int k = 0; k < n; k++) begin
         acc = times_alpha(acc);
      end
      return acc;
   endfunction

   // Smallest exponent e with alpha^e == x; returns 0 when x is not a power.
   function automatic bit find_log(input logic [7:0] x, output logic [7:0] e);
      logic [7:0] p;
      p = 8'h01;
      e = '0;
      for (int k = 0; k < 255; k++) begin
         if (p == x) begin
            e = 8'(k);
            return 1'b1;
         end
         p = times_alpha(p);
      end
      return 1'b0;
   endfunction

   function automatic void syndromes(input word_type w, output logic [7:0] s0,
                                     output logic [7:0] s1);
      s0 = '0;
      s1 = '0;
      for (int i = 0; i < 10; i++) begin
         s0 ^= w[i];
         s1 ^= scale_by_alpha(w[i], i);
      end
   endfunction

   // A single bad symbol at j gives S1 = S0 * alpha^j. Anything else that
   // leaves a syndrome nonzero is flagged uncorrectable with the word intact.
   function automatic result_type decode_word(input word_type w);
      result_type r;
      logic [7:0] s0, s1, l0, l1;
      int         j;
      r.fix = w;
      r.st  = ST_DUE;
      r.pos = '0;
      syndromes(w, s0, s1);
      if (s0 == 8'h00 && s1 == 8'h00) begin
         r.st = ST_NONE;
      end else if (s0 != 8'h00 && s1 != 8'h00 && find_log(s0, l0) && find_log(s1, l1)) begin
         j = (int'(l1) + 255 - int'(l0)) % 255;
         if (j < 10) begin
            r.fix[j] = w[j] ^ s0;
            r.st     = ST_CORR;
            r.pos    = 4'(j);
         end
      end
      return r;
   endfunction

   // Random data symbols with the two check symbols solved so that both
   // syndromes vanish; the 2x2 system always has exactly one solution.
   function automatic word_type make_codeword();
      word_type   w;
      logic [7:0] a, b, c8;
      for (int i = 0; i < 8; i++) begin
         w[i] = 8'($urandom);
      end
      w[8] = '0;
      w[9] = '0;
      syndromes(w, a, b);
      for (int c = 0; c < 256; c++) begin
         c8 = a ^ 8'(c);
         if ((scale_by_alpha(c8, 8) ^ scale_by_alpha(8'(c), 9)) == b) begin
            w[8] = c8;
            w[9] = 8'(c);
            return w;
         end
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one word, holding it steady while stalled. The expectation joins
   // the queue at the edge where the word is taken, so queue order is word
   // order.
   task automatic send_word(input word_type w, input result_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sym_0 <= w[0];
      req_sym_1 <= w[1];
      req_sym_2 <= w[2];
      req_sym_3 <= w[3];
      req_sym_4 <= w[4];
      req_sym_5 <= w[5];
      req_sym_6 <= w[6];
      req_sym_7 <= w[7];
      req_sym_8 <= w[8];
      req_sym_9 <= w[9];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_decodes.push_back(r);
      words_sent++;
   endtask

   // Mostly valid codewords with zero, one or two bad symbols, plus some
   // pure noise, which lands almost always on an out-of-range position.
   task automatic send_random_phase(input int count);
      word_type w;
      int       pick;
      for (int n = 0; n < count; n++) begin
         w    = make_codeword();
         pick = $urandom_range(99);
         if (pick >= 20 && pick < 85) begin
            w[$urandom_range(9)] ^= 8'($urandom_range(255, 1));
            if (pick >= 70) begin
               w[$urandom_range(9)] ^= 8'($urandom_range(255, 1));
            end
         end else if (pick >= 85) begin
            w = 80'({$urandom(), $urandom(), $urandom()});
         end
         send_word(w, decode_word(w));
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // The receiver stalls at random, and once per run holds off for a long
   // stretch so that the queue fills and the request side gets stalled.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Every word handed over is checked against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.fix = {rsp_fix_0, rsp_fix_1, rsp_fix_2, rsp_fix_3, rsp_fix_4,
                    rsp_fix_5, rsp_fix_6, rsp_fix_7, rsp_fix_8, rsp_fix_9};
         got.st  = status_type'(rsp_status);
         got.pos = rsp_err_pos;
         if (expected_decodes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0d] unexpected response word: fix=%h status=%0d pos=%0d",
                        cycle_count, got.fix, got.st, got.pos);
            end
         end else begin
            want = expected_decodes.pop_front();
            words_checked++;
            if (got.fix !== want.fix || got.st !== want.st || got.pos !== want.pos) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0d] word %0d: expected fix=%h status=%0d pos=%0d",
                           cycle_count, words_checked - 1, want.fix, want.st, want.pos);
                  $display("[%0d] word %0d:   actual fix=%h status=%0d pos=%0d",
                           cycle_count, words_checked - 1, got.fix, got.st, got.pos);
               end
            end else begin
               case (want.st)
                  ST_NONE: seen_clean++;
                  ST_CORR: seen_corrected++;
                  default: seen_uncorrectable++;
               endcase
            end
         end
      end
   end

   // Cycle count, input back-pressure count and the run-away guard.
   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && req_stall) begin
         blocked_cycles++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding",
                  cycle_count, expected_decodes.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin : sequencer
      result_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words go in back to back against a receiver that never stalls.
      for (int k = 0; k < NDIR; k++) begin
         if (directed_rows[k].known) begin
            r.fix = directed_rows[k].fix;
            r.st  = directed_rows[k].st;
            r.pos = directed_rows[k].pos;
         end else begin
            r = decode_word(directed_rows[k].sym);
         end
         send_word(directed_rows[k].sym, r);
      end

      // A busy sender against a busy receiver.
      send_idle_pct = 25;
      recv_idle_pct = 59;
      send_random_phase(PHASE_WORDS);

      // A sparse sender against a mostly ready receiver.
      send_idle_pct = 59;
      recv_idle_pct = 25;
      send_random_phase(PHASE_WORDS);

      // Full rate both ways, opening with the long receiver hold-off while
      // the sender keeps offering words.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed    = 1'b1;
      send_random_phase(PHASE_WORDS);
      req_valid <= 1'b0;

      while (expected_decodes.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d words, checked %0d: %0d clean, %0d corrected, %0d uncorrectable",
               words_sent, words_checked, seen_clean, seen_corrected, seen_uncorrectable);
      $display("Request side was held off for %0d cycles; %0d mismatches in %0d cycles",
               blocked_cycles, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
